>>> hdl/umc_pkg.sv
// Shared constants, types and helper function of the UPGMA cluster merger.
`timescale 1ns / 1ps
`default_nettype none
package umc_pkg;

  localparam int MAX_LEAVES = 64;
  localparam int ID_W       = $clog2(MAX_LEAVES);
  localparam int CNT_W      = ID_W + 1;
  localparam int SIZE_W     = 7;
  localparam int DIST_W     = 32;
  localparam int ACC_W      = DIST_W + SIZE_W;
  localparam int ADDR_W     = 2 * ID_W;
  localparam int DIV_CNT_W  = $clog2(ACC_W);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_ROW, S_ROWW, S_COLR, S_COLW, S_CMP,
    S_SX, S_SY, S_SYW, S_CR, S_CU, S_DX, S_DY, S_M2,
    S_DST, S_DIVW, S_WR, S_APP, S_EMIT
  } umc_state_e;

  // The matrix is symmetric, so only the entry with the smaller id first is kept.
  function automatic logic [ADDR_W-1:0] dist_addr(input logic [ID_W-1:0] a,
                                                   input logic [ID_W-1:0] b);
    dist_addr = (a < b) ? {a, b} : {b, a};
  endfunction

endpackage
`default_nettype wire

>>> hdl/umc_if.sv
// Valid/ready channel interfaces of the UPGMA cluster merger.
`timescale 1ns / 1ps
`default_nettype none
interface umc_req_if import umc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   row_leaf;
  logic [ID_W-1:0]   col_leaf;
  logic [DIST_W-1:0] distance;
  modport source (output valid, req_type, row_leaf, col_leaf, distance, input ready);
  modport sink   (input valid, req_type, row_leaf, col_leaf, distance, output ready);
endinterface

interface umc_res_if import umc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   first_id;
  logic [ID_W-1:0]   second_id;
  logic [DIST_W-1:0] merge_distance;
  logic [SIZE_W-1:0] merged_size;
  logic              last;
  modport source (output valid, first_id, second_id, merge_distance, merged_size, last,
                  input ready);
  modport sink   (input valid, first_id, second_id, merge_distance, merged_size, last,
                  output ready);
endinterface

interface umc_cfg_if import umc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hdl/umc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module umc_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/umc_div.sv
// Restoring divider, one quotient bit per cycle, for the size-weighted mean.
`timescale 1ns / 1ps
`default_nettype none
module umc_div import umc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ACC_W-1:0]  dividend_i,
  input  wire logic [SIZE_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [DIST_W-1:0] quotient_o
);

  localparam logic [DIV_CNT_W-1:0] LastStep = DIV_CNT_W'(ACC_W - 1);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0]     dvd_q;
  logic [SIZE_W-1:0]    rem_q, div_q;
  logic [SIZE_W:0]      trial;
  logic                 ge;

  // One shift-and-subtract step.
  assign trial = {rem_q, dvd_q[ACC_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  // Control: busy flag, step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in at the bottom of the dividend.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[ACC_W-2:0], ge};
      rem_q <= ge ? SIZE_W'(trial - {1'b0, div_q}) : trial[SIZE_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q[DIST_W-1:0];

endmodule
`default_nettype wire

>>> hdl/upgma_cluster_merger_core.sv
// UPGMA merger: loads stream at one per cycle while the sequencer is idle. A start
// transfer sets up the active list. Each merge then scans the pairs row by row, reads
// the sizes and, per surviving cluster, forms the weighted mean (39-step bit-serial divider
// behind the shared multiplier), then skips, appends and reports, plus any stall while
// the previous result waits.
// Reset (asynchronous, active low) idles the sequencer, sets leaf_count to 2; RAMs undefined.
`timescale 1ns / 1ps
`default_nettype none
module upgma_cluster_merger_core import umc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  umc_req_if.sink    req_i,
  umc_res_if.source  res_o,
  umc_cfg_if.sink    cfg_i
);

  umc_state_e        state_q, state_d;
  logic [CNT_W-1:0]  lc_q, cnt_q, cnt_d, k_q, k_d, i_q, i_d, j_q, j_d, r_q, r_d, w_q, w_d;
  logic [ID_W-1:0]   a_id_q, a_id_d, b_id_q, b_id_d, bi_q, bi_d, bj_q, bj_d;
  logic [ID_W-1:0]   idx_q, idx_d, idy_q, idy_d, u_q, u_d;
  logic [DIST_W-1:0] best_q, best_d, dx_q, dx_d, dy_q, dy_d;
  logic [SIZE_W-1:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [ACC_W-1:0]  acc_q, acc_d, prod;
  logic [DIST_W-1:0] mul_a;
  logic [SIZE_W-1:0] mul_b;
  logic              first_q, first_d, out_v_q, out_v_d, out_load;
  logic [CNT_W-1:0]  n_start;

  logic [ID_W-1:0]   out_first_q, out_second_q;
  logic [DIST_W-1:0] out_dist_q;
  logic [SIZE_W-1:0] out_size_q;
  logic              out_last_q;

  // RAM ports.
  logic              d_we, ao_we, sz_we;
  logic [ADDR_W-1:0] d_waddr, d_raddr;
  logic [DIST_W-1:0] d_wdata, d_rdata;
  logic [ID_W-1:0]   ao_waddr, ao_raddr, ao_wdata, ao_rdata, sz_waddr, sz_raddr;
  logic [SIZE_W-1:0] sz_wdata, sz_rdata;
  logic              div_start, div_done;
  logic [DIST_W-1:0] div_quot;

  umc_ram #(.Width(DIST_W), .Depth(MAX_LEAVES * MAX_LEAVES)) u_dist_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  umc_ram #(.Width(ID_W), .Depth(MAX_LEAVES)) u_order_ram (
    .clk_i, .we_i(ao_we), .waddr_i(ao_waddr), .wdata_i(ao_wdata),
    .raddr_i(ao_raddr), .rdata_o(ao_rdata)
  );

  umc_ram #(.Width(SIZE_W), .Depth(MAX_LEAVES)) u_size_ram (
    .clk_i, .we_i(sz_we), .waddr_i(sz_waddr), .wdata_i(sz_wdata),
    .raddr_i(sz_raddr), .rdata_o(sz_rdata)
  );

  umc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(acc_q), .divisor_i(sz_q),
    .done_o(div_done), .quotient_o(div_quot)
  );

  // Leaf count clamped to the supported range.
  always_comb begin
    if (lc_q < CNT_W'(2)) begin
      n_start = CNT_W'(2);
    end else if (lc_q > CNT_W'(MAX_LEAVES)) begin
      n_start = CNT_W'(MAX_LEAVES);
    end else begin
      n_start = lc_q;
    end
  end

  // Shared multiplier for both weighted terms.
  assign mul_a = (state_q == S_DY) ? dx_q : dy_q;
  assign mul_b = (state_q == S_DY) ? sx_q : sy_q;
  assign prod  = mul_a * mul_b;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Sequencer: next state, datapath updates and RAM controls.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  k_d = k_q;  i_d = i_q;  j_d = j_q;  r_d = r_q;  w_d = w_q;
    a_id_d = a_id_q;  b_id_d = b_id_q;  bi_d = bi_q;  bj_d = bj_q;
    idx_d = idx_q;  idy_d = idy_q;  u_d = u_q;  best_d = best_q;
    dx_d = dx_q;  dy_d = dy_q;  sx_d = sx_q;  sy_d = sy_q;  sz_d = sz_q;
    acc_d = acc_q;  first_d = first_q;
    out_load = 1'b0;
    d_we = 1'b0;  d_waddr = dist_addr(req_i.row_leaf, req_i.col_leaf);
    d_wdata = req_i.distance;  d_raddr = dist_addr(a_id_q, ao_rdata);
    ao_we = 1'b0;  ao_waddr = w_q[ID_W-1:0];  ao_wdata = u_q;  ao_raddr = i_q[ID_W-1:0];
    sz_we = 1'b0;  sz_waddr = idx_q;  sz_wdata = SIZE_W'(sx_q + sz_rdata);
    sz_raddr = idx_q;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.req_type) begin
            cnt_d   = n_start;
            k_d     = '0;
            state_d = S_INIT;
          end else begin
            d_we = 1'b1;
          end
        end
      end
      S_INIT: begin
        ao_we    = 1'b1;
        ao_waddr = k_q[ID_W-1:0];
        ao_wdata = k_q[ID_W-1:0];
        sz_we    = 1'b1;
        sz_waddr = k_q[ID_W-1:0];
        sz_wdata = SIZE_W'(1);
        k_d      = k_q + 1'b1;
        if (k_q + 1'b1 == cnt_q) begin
          i_d     = '0;
          first_d = 1'b1;
          state_d = S_ROW;
        end
      end
      // Pair scan over the active list.
      S_ROW: begin
        ao_raddr = i_q[ID_W-1:0];
        state_d  = S_ROWW;
      end
      S_ROWW: begin
        a_id_d  = ao_rdata;
        j_d     = i_q + 1'b1;
        state_d = S_COLR;
      end
      S_COLR: begin
        ao_raddr = j_q[ID_W-1:0];
        state_d  = S_COLW;
      end
      S_COLW: begin
        b_id_d  = ao_rdata;
        d_raddr = dist_addr(a_id_q, ao_rdata);
        state_d = S_CMP;
      end
      S_CMP: begin
        first_d = 1'b0;
        if (first_q || (d_rdata < best_q)) begin
          best_d = d_rdata;
          bi_d   = i_q[ID_W-1:0];
          bj_d   = j_q[ID_W-1:0];
          idx_d  = a_id_q;
          idy_d  = b_id_q;
        end
        if (j_q + 1'b1 < cnt_q) begin
          j_d     = j_q + 1'b1;
          state_d = S_COLR;
        end else if (i_q + CNT_W'(2) < cnt_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_ROW;
        end else begin
          state_d = S_SX;
        end
      end
      // Cluster sizes of the chosen pair.
      S_SX: begin
        sz_raddr = idx_q;
        state_d  = S_SY;
      end
      S_SY: begin
        sx_d     = sz_rdata;
        sz_raddr = idy_q;
        state_d  = S_SYW;
      end
      S_SYW: begin
        sy_d     = sz_rdata;
        sz_d     = SIZE_W'(sx_q + sz_rdata);
        sz_we    = 1'b1;
        sz_waddr = idx_q;
        r_d      = '0;
        w_d      = '0;
        state_d  = S_CR;
      end
      // Compaction pass that also refreshes the merged row.
      S_CR: begin
        if (r_q == cnt_q) begin
          state_d = S_APP;
        end else if ((r_q[ID_W-1:0] == bi_q) || (r_q[ID_W-1:0] == bj_q)) begin
          r_d = r_q + 1'b1;
        end else begin
          ao_raddr = r_q[ID_W-1:0];
          state_d  = S_CU;
        end
      end
      S_CU: begin
        u_d     = ao_rdata;
        d_raddr = dist_addr(ao_rdata, idx_q);
        state_d = S_DX;
      end
      S_DX: begin
        dx_d    = d_rdata;
        d_raddr = dist_addr(u_q, idy_q);
        state_d = S_DY;
      end
      S_DY: begin
        dy_d    = d_rdata;
        acc_d   = prod;
        state_d = S_M2;
      end
      S_M2: begin
        acc_d   = acc_q + prod;
        state_d = S_DST;
      end
      S_DST: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        d_we     = 1'b1;
        d_waddr  = dist_addr(idx_q, u_q);
        d_wdata  = div_quot;
        ao_we    = 1'b1;
        ao_waddr = w_q[ID_W-1:0];
        ao_wdata = u_q;
        w_d      = w_q + 1'b1;
        r_d      = r_q + 1'b1;
        state_d  = S_CR;
      end
      S_APP: begin
        ao_we    = 1'b1;
        ao_waddr = w_q[ID_W-1:0];
        ao_wdata = idx_q;
        cnt_d    = w_q + 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_v_q) begin
          out_load = 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            i_d     = '0;
            first_d = 1'b1;
            state_d = S_ROW;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register holds a result until its transfer.
  assign out_v_d = out_load | (out_v_q & ~res_o.ready);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lc_q    <= CNT_W'(2);
      cnt_q   <= '0;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      r_q     <= '0;
      w_q     <= '0;
      first_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        lc_q <= cfg_i.data;
      end
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      r_q     <= r_d;
      w_q     <= w_d;
      first_q <= first_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_id_q <= a_id_d;
    b_id_q <= b_id_d;
    bi_q   <= bi_d;
    bj_q   <= bj_d;
    idx_q  <= idx_d;
    idy_q  <= idy_d;
    u_q    <= u_d;
    best_q <= best_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    sz_q   <= sz_d;
    acc_q  <= acc_d;
    if (out_load) begin
      out_first_q  <= idx_q;
      out_second_q <= idy_q;
      out_dist_q   <= best_q;
      out_size_q   <= sz_q;
      out_last_q   <= (cnt_q == CNT_W'(1));
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.first_id       = out_first_q;
  assign res_o.second_id      = out_second_q;
  assign res_o.merge_distance = out_dist_q;
  assign res_o.merged_size    = out_size_q;
  assign res_o.last           = out_last_q;

`ifndef SYNTHESIS
  // A free output register is always filled when a merge is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_v_q) |=> out_v_q)
    else $error("merge result not registered");

  // The scan only compares ordered pairs inside the active list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (i_q < j_q && j_q < cnt_q))
    else $error("pair scan out of range");

  // Compaction never writes ahead of the entry being read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CR) |-> (w_q <= r_q))
    else $error("compaction overtook read pointer");
`endif

endmodule
`default_nettype wire
